### hdl/sha256_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 package
// Round constants, initial hash values and round functions.
// ----------------------------------------------------------------------------
`default_nettype none

package sha256_pkg;

	typedef logic [31:0] word_t;

	// controller -> datapath commands
	typedef struct packed {
		logic       init_hash;   // load initial hash, clear length
		logic       write_byte;  // store a byte at fill position
		logic [7:0] wr_byte;
		logic       count_bits;  // add 8 to message bit count
		logic       clear_fill;
		logic       start_blk;   // working vars <= chain hash, round 0
		logic       do_round;
		logic       fold;        // chain hash += working vars
		logic [1:0] out_sel;
	} dp_cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic [6:0] fill;
		logic       last_round;
		logic [7:0] len_byte;    // length byte for the current fill position
	} dp_stat_t;

	localparam word_t H_INIT [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	localparam word_t K_TAB [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	localparam logic [7:0] PAD_BYTE  = 8'h80;
	localparam int         LEN_POS   = 56;
	localparam int         BLK_BYTES = 64;

	function automatic word_t rotr(input word_t x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t sig0(input word_t x);
		sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t sig1(input word_t x);
		sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic word_t bsig0(input word_t x);
		bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t bsig1(input word_t x);
		bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

endpackage

`default_nettype wire

### hdl/sha256_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire                     clk,
	input  wire                     wr_en,
	input  wire [$clog2(DEPTH)-1:0] wr_addr,
	input  wire [WIDTH-1:0]         wr_data,
	input  wire [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]        rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

### hdl/sha256_datapath.sv
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Block buffer, message schedule, round logic, chain hash and length.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_datapath (
	input  wire                  clk,
	input  wire                  arst_n,
	input  sha256_pkg::dp_cmd_t  cmd,
	output sha256_pkg::dp_stat_t stat,
	output logic [63:0]          out_word
);
	import sha256_pkg::*;

	word_t       h_q [8];
	word_t       v_q [8];
	word_t       w_q [16];
	logic [63:0] bits_q;
	logic [6:0]  fill_q;
	logic [5:0]  rnd_q;
	logic [31:0] blk_rdata;
	logic [3:0]  blk_raddr;
	logic [5:0]  waddr;
	logic        bank_we;

	// Block buffer stored as four byte lanes of 16 words; lane 0 is MSB.
	assign waddr   = fill_q[5:0];
	assign bank_we = cmd.write_byte;
	// Read address of next round's word, issued ahead because the buffer read is registered.
	assign blk_raddr = cmd.start_blk ? 4'd0 : (rnd_q[3:0] + 4'd1);

	for (genvar g = 0; g < 4; g++) begin : g_lane
		sha256_ram #(.WIDTH(8), .DEPTH(16)) u_ram (
			.clk     (clk),
			.wr_en   (bank_we && (waddr[1:0] == 2'(g))),
			.wr_addr (waddr[5:2]),
			.wr_data (cmd.wr_byte),
			.rd_addr (blk_raddr),
			.rd_data (blk_rdata[31-8*g -: 8])
		);
	end

	word_t w_new, t1, t2;

	always_comb begin
		if (rnd_q < 6'd16) begin
			w_new = blk_rdata;
		end else begin
			w_new = w_q[0] + sig0(w_q[1]) + w_q[9] + sig1(w_q[14]);
		end
		t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ K_TAB[rnd_q] + w_new;
		t2 = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q    <= H_INIT;
			bits_q <= '0;
			fill_q <= '0;
			rnd_q  <= '0;
		end else begin
			if (cmd.write_byte) begin
				fill_q <= fill_q + 7'd1;
			end
			if (cmd.clear_fill) begin
				fill_q <= '0;
			end
			if (cmd.count_bits) begin
				bits_q <= bits_q + 64'd8;
			end
			if (cmd.start_blk) begin
				rnd_q <= '0;
			end else if (cmd.do_round) begin
				rnd_q <= rnd_q + 6'd1;
			end
			if (cmd.fold) begin
				for (int i = 0; i < 8; i++) begin
					h_q[i] <= h_q[i] + v_q[i];
				end
			end
			if (cmd.init_hash) begin
				h_q    <= H_INIT;
				bits_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_blk) begin
			v_q <= h_q;
		end else if (cmd.do_round) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= w_new;
		end
	end

	// Big-endian length byte for fill positions 56..63.
	logic [7:0] len_byte;
	assign len_byte = bits_q[8*(7 - fill_q[2:0]) +: 8];

	assign stat.fill       = fill_q;
	assign stat.last_round = (rnd_q == 6'd63);
	assign stat.len_byte   = len_byte;
	assign out_word = {h_q[{cmd.out_sel, 1'b0}], h_q[{cmd.out_sel, 1'b1}]};

endmodule

`default_nettype wire

### hdl/sha256_ctrl.sv
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences byte loads, padding, compression and digest output.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  wire [7:0]            in_byte,
	input  wire                  in_present,
	input  wire                  in_eom,
	output sha256_pkg::dp_cmd_t  cmd,
	input  sha256_pkg::dp_stat_t stat,
	output logic                 out_valid,
	input  wire                  out_ready,
	output logic [1:0]           out_idx
);
	import sha256_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PRE  = 3'd1;  // issues the first buffer read
	localparam logic [2:0] ST_RND  = 3'd2;
	localparam logic [2:0] ST_FOLD = 3'd3;
	localparam logic [2:0] ST_PAD  = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [2:0] state_q;
	logic       eom_q;      // message end pending
	logic       pad_q;      // 0x80 byte written
	logic       spill_q;    // 0x80 landed in the length field; length goes in next block
	logic       len_done_q; // finished block carried the length
	logic [1:0] idx_q;

	logic acc;
	assign acc      = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign out_idx   = idx_q;

	logic [7:0] pad_byte;
	always_comb begin
		if (!pad_q) begin
			pad_byte = PAD_BYTE;
		end else if (stat.fill >= 7'(LEN_POS) && !spill_q) begin
			pad_byte = stat.len_byte;
		end else begin
			pad_byte = 8'd0;
		end
	end

	always_comb begin
		cmd = '0;
		cmd.out_sel = idx_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc && in_present) begin
					cmd.write_byte = 1'b1;
					cmd.wr_byte    = in_byte;
					cmd.count_bits = 1'b1;
				end
			end
			ST_PAD: begin
				cmd.write_byte = 1'b1;
				cmd.wr_byte    = pad_byte;
			end
			ST_PRE: begin
				cmd.start_blk = 1'b1;
				cmd.clear_fill = 1'b1;
			end
			ST_RND: begin
				cmd.do_round = 1'b1;
			end
			ST_FOLD: begin
				cmd.fold = 1'b1;
			end
			ST_OUT: begin
				if (out_ready && idx_q == 2'd3) begin
					cmd.init_hash = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			eom_q   <= 1'b0;
			pad_q   <= 1'b0;
			spill_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						eom_q <= in_eom;
						pad_q <= 1'b0;
						if (in_present && stat.fill == 7'(BLK_BYTES - 1)) begin
							state_q <= ST_PRE;
						end else if (in_eom) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					pad_q <= 1'b1;
					if (!pad_q && stat.fill >= 7'(LEN_POS)) begin
						spill_q <= 1'b1;
					end
					if (stat.fill == 7'(BLK_BYTES - 1)) begin
						state_q <= ST_PRE;
					end
				end
				ST_PRE: begin
					spill_q <= 1'b0;
					state_q <= ST_RND;
				end
				ST_RND: begin
					if (stat.last_round) begin
						state_q <= ST_FOLD;
					end
				end
				ST_FOLD: begin
					if (!eom_q) begin
						state_q <= ST_IDLE;
					end else if (pad_q && stat.fill == 7'd0 && len_done_q) begin
						state_q <= ST_OUT;
						idx_q   <= '0;
					end else begin
						state_q <= ST_PAD;
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						idx_q <= idx_q + 2'd1;
						if (idx_q == 2'd3) begin
							state_q <= ST_IDLE;
							eom_q   <= 1'b0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Length is in the finished block when its last byte was written after
	// the pad and the pad did not spill into the length field.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_done_q <= 1'b0;
		end else if (state_q == ST_IDLE) begin
			len_done_q <= 1'b0;
		end else if (state_q == ST_PAD && pad_q && !spill_q
				&& stat.fill == 7'(BLK_BYTES - 1)) begin
			len_done_q <= 1'b1;
		end
	end

endmodule

`default_nettype wire

### hdl/sha256_stream_hasher.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Hashes a byte stream; emits the digest as four 64-bit words.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle until a block fills; input then waits while
//   the block compresses (buffer read lead-in, 64 rounds, hash fold).
// End of message: pad bytes are written one per cycle, then one or two more
//   compressions; the digest follows as four transfers, word 0 first.
// Input is held off while pad bytes are written, while a block compresses and while the digest drains.
// Reset (arst_n low) loads the initial hash and clears length and fill count.
`default_nettype none

module sha256_stream_hasher (
	input  wire         clk,
	input  wire         arst_n,
	// s_tdata: [7:0] data_byte, [8] byte_present
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire [15:0]  s_tdata,
	input  wire         s_tlast,     // end_of_message
	// m_tdata: [63:0] digest_word
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [63:0] m_tdata,
	output logic [1:0]  m_tuser,     // word_index
	output logic        m_tlast      // last_word
);
	import sha256_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	sha256_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_byte    (s_tdata[7:0]),
		.in_present (s_tdata[8]),
		.in_eom     (s_tlast),
		.cmd        (cmd),
		.stat       (stat),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_idx    (m_tuser)
	);

	sha256_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.out_word (m_tdata)
	);

	assign m_tlast = (m_tuser == 2'd3);

endmodule

`default_nettype wire

### bench/tb.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Feeds byte messages, predicts each digest in the bench and checks every
// digest word transfer in order, under several idle/stall mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sha256_pkg::word_t;
	import sha256_pkg::H_INIT;
	import sha256_pkg::K_TAB;

	typedef struct {
		logic [63:0] word;
		logic [1:0]  index;
		logic        last;
	} digest_xfer_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	sha256_stream_hasher DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	always #4 clk = ~clk;

	// predictor state
	word_t       hash_chain [8];
	logic [7:0]  blk_bytes [64];
	int          blk_fill;
	logic [63:0] bit_len;
	digest_xfer_t expected_words [$];

	int errors = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit recv_hold = 1'b0;
	int idle_cycles = 0;

	function automatic word_t ror(word_t x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic compress();
		word_t w [64];
		word_t v [8];
		word_t t1, t2;
		for (int i = 0; i < 16; i++)
			w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
		for (int i = 16; i < 64; i++)
			w[i] = w[i-16] + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
				+ w[i-7] + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
		v = hash_chain;
		for (int r = 0; r < 64; r++) begin
			t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[r] + w[r];
			t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			hash_chain[i] += v[i];
	endtask

	task automatic restart_message();
		hash_chain = H_INIT;
		blk_fill = 0;
		bit_len = '0;
	endtask

	// advance the digest model by one accepted input transfer
	task automatic predict_digest(logic [7:0] b, logic present, logic eom);
		int i;
		digest_xfer_t x;
		if (present) begin
			blk_bytes[blk_fill] = b;
			blk_fill++;
			bit_len += 64'd8;
			if (blk_fill == 64) begin
				compress();
				blk_fill = 0;
			end
		end
		if (eom) begin
			i = blk_fill;
			blk_bytes[i] = 8'h80;
			i++;
			if (i > 56) begin
				while (i < 64) begin
					blk_bytes[i] = 8'h00;
					i++;
				end
				compress();
				i = 0;
			end
			while (i < 56) begin
				blk_bytes[i] = 8'h00;
				i++;
			end
			for (int k = 0; k < 8; k++)
				blk_bytes[63-k] = bit_len[8*k +: 8];
			compress();
			for (int k = 0; k < 4; k++) begin
				x.word = {hash_chain[2*k], hash_chain[2*k+1]};
				x.index = 2'(k);
				x.last = (k == 3);
				expected_words.push_back(x);
			end
			restart_message();
		end
	endtask

	// one input transfer; random sender idle before it. tvalid stays high
	// after the transfer and drops in the next idle cycle or drain wait.
	task automatic send_byte(logic [7:0] b, logic present, logic eom);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, present, b};
		s_tlast <= eom;
		do @(posedge clk); while (!s_tready);
		predict_digest(b, present, eom);
	endtask

	task automatic send_message(int len, bit with_gap_bytes);
		for (int i = 0; i < len; i++) begin
			if (with_gap_bytes && $urandom_range(9) == 0)
				send_byte(8'($urandom), 1'b0, 1'b0);
			send_byte(8'($urandom), 1'b1, (i == len - 1));
		end
		if (len == 0)
			send_byte(8'($urandom), 1'b0, 1'b1);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (expected_words.size() != 0);
	endtask

	// receiver ready and digest word checker
	always @(posedge clk) begin
		digest_xfer_t e;
		if (m_tvalid && m_tready) begin
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected digest word %h", $time, m_tdata);
				errors++;
			end else begin
				e = expected_words.pop_front();
				if (m_tdata !== e.word || m_tuser !== e.index || m_tlast !== e.last) begin
					$display("%0t: digest mismatch exp %h/%0d/%b got %h/%0d/%b", $time,
						e.word, e.index, e.last, m_tdata, m_tuser, m_tlast);
					errors++;
				end
			end
		end
		m_tready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic test_directed();
		send_byte(8'h00, 1'b0, 1'b1);                // empty message
		send_byte(8'h61, 1'b1, 1'b0);                // "abc"
		send_byte(8'h62, 1'b1, 1'b0);
		send_byte(8'h63, 1'b1, 1'b1);
		send_byte(8'hff, 1'b1, 1'b0);
		send_byte(8'h00, 1'b1, 1'b0);
		send_byte(8'h5a, 1'b0, 1'b0);                // no byte, not last
		send_byte(8'ha5, 1'b0, 1'b1);                // end with no byte
		send_byte(8'hff, 1'b1, 1'b1);
		wait_drained();
	endtask

	// lengths around the pad boundaries: 55/56 fit or spill, 64 full block
	task automatic test_pad_boundaries();
		int lens [5] = '{55, 56, 57, 63, 64};
		foreach (lens[i]) send_message(lens[i], 1'b0);
		wait_drained();
	endtask

	task automatic test_random_phase(int idle_pct, int stall_pct, int nbytes);
		int sent = 0;
		int len;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		while (sent < nbytes) begin
			len = ($urandom_range(7) == 0) ? $urandom_range(130) : $urandom_range(20);
			send_message(len, 1'b1);
			sent += len;
		end
		wait_drained();
	endtask

	// receiver held off while messages keep coming, then sender waits for drain
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		recv_hold = 1'b1;
		fork
			begin
				repeat (600) @(posedge clk);
				recv_hold = 1'b0;
			end
			for (int i = 0; i < 6; i++) send_message($urandom_range(8), 1'b0);
		join
		wait_drained();
		send_message(3, 1'b0);
		wait_drained();
	endtask

	initial begin
		restart_message();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_pad_boundaries();
		test_backpressure();
		test_random_phase(0, 0, 40);
		test_random_phase(69, 0, 40);
		test_random_phase(0, 69, 40);
		test_random_phase(28, 28, 40);
		repeat (200) @(posedge clk);
		if (errors == 0 && expected_words.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire

### sim.f
hdl/sha256_pkg.sv
hdl/sha256_ram.sv
hdl/sha256_datapath.sv
hdl/sha256_ctrl.sv
hdl/sha256_stream_hasher.sv
bench/tb.sv
